FILE: design/bpt_pkg.sv
// Shared constants, codes and payload types of the bounded pheromone table.
package bpt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int STORE_DEPTH  = MAX_VERTICES * MAX_VERTICES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int IDX_W        = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VC_W         = 7;
    localparam int CMP_W        = (VC_W > CNT_W) ? VC_W : CNT_W;

    localparam int OP_W       = 3;
    localparam int ROW_W      = 6;
    localparam int AMT_W      = 17;
    localparam int VAL_W      = 32;
    localparam int DECAY_W    = 16;
    localparam int INV_W      = 24;
    localparam int FLOOR_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [VAL_W-1:0]   ONE_Q16         = 32'h0001_0000;
    localparam logic [VC_W-1:0]    RST_VERTEX      = 7'd64;
    localparam logic [DECAY_W-1:0] RST_DECAY       = 16'd52429;
    localparam logic [INV_W-1:0]   RST_INV         = 24'd327680;
    localparam logic [FLOOR_W-1:0] RST_FLOOR_RATIO = 16'd328;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 3'd0,
        OP_EVAP    = 3'd1,
        OP_DEPOSIT = 3'd2,
        OP_OFFER   = 3'd3,
        OP_READ    = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT      = 2'd0,
        CFG_DECAY             = 2'd1,
        CFG_INV_ONE_MINUS_RHO = 2'd2,
        CFG_FLOOR_RATIO       = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_EVAP,
        ST_DEP_WAIT,
        ST_BEST_MAX,
        ST_BEST_MIN,
        ST_FETCH,
        ST_DATA
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [AMT_W-1:0] amount;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] entry_value;
        logic [AMT_W-1:0] best_score;
        logic [VAL_W-1:0] lower_bound;
        logic [VAL_W-1:0] upper_bound;
        logic             improved;
        logic             status;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic              bad;
        logic [AMT_W-1:0]  amount;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [DECAY_W-1:0] decay;
        logic [INV_W-1:0]   inv_one_minus_rho;
        logic [FLOOR_W-1:0] floor_ratio;
    } t_cfg;

endpackage

FILE: design/bpt_front.sv
// Front end: configuration registers and classification of incoming item beats.
module bpt_front
    import bpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in                   i_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_full
);

    logic [VC_W-1:0]    r_vertex_count;
    logic [DECAY_W-1:0] r_decay;
    logic [INV_W-1:0]   r_inv;
    logic [FLOOR_W-1:0] r_floor_ratio;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   row_ext;
    logic [CMP_W-1:0]   col_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= RST_VERTEX;
            r_decay        <= RST_DECAY;
            r_inv          <= RST_INV;
            r_floor_ratio  <= RST_FLOOR_RATIO;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_VERTEX_COUNT:      r_vertex_count <= i_cfg_data[VC_W-1:0];
                CFG_DECAY:             r_decay        <= i_cfg_data[DECAY_W-1:0];
                CFG_INV_ONE_MINUS_RHO: r_inv          <= i_cfg_data[INV_W-1:0];
                CFG_FLOOR_RATIO:       r_floor_ratio  <= i_cfg_data[FLOOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (CMP_W'(r_vertex_count) > CMP_W'(MAX_VERTICES)) begin
            count_ext = CMP_W'(MAX_VERTICES);
        end else begin
            count_ext = CMP_W'(r_vertex_count);
        end
    end

    assign row_ext = CMP_W'(i_item.row);
    assign col_ext = CMP_W'(i_item.col);

    always_comb begin
        o_cfg.count             = count_ext[CNT_W-1:0];
        o_cfg.decay             = r_decay;
        o_cfg.inv_one_minus_rho = r_inv;
        o_cfg.floor_ratio       = r_floor_ratio;
    end

    always_comb begin
        o_cmd.op     = i_item.opcode;
        o_cmd.addr   = ADDR_W'(ADDR_W'(i_item.row) * ADDR_W'(MAX_VERTICES)
                       + ADDR_W'(i_item.col));
        o_cmd.bad    = (row_ext >= count_ext) || (col_ext >= count_ext);
        o_cmd.amount = i_item.amount;
    end

    assign full       = i_cmd_full;
    assign o_cmd_push = push && !i_cmd_full;

endmodule

FILE: design/bpt_cmd_queue.sv
// Short command queue that decouples the front end from the execution back end.
module bpt_cmd_queue
    import bpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_q [CMDQ_DEPTH];
    logic [CMDQ_PTR_W:0] r_wr_ptr;
    logic [CMDQ_PTR_W:0] r_rd_ptr;

    assign o_valid = (r_wr_ptr != r_rd_ptr);
    assign o_full  = (r_wr_ptr[CMDQ_PTR_W] != r_rd_ptr[CMDQ_PTR_W])
                     && (r_wr_ptr[CMDQ_PTR_W-1:0] == r_rd_ptr[CMDQ_PTR_W-1:0]);
    assign o_cmd   = r_q[r_rd_ptr[CMDQ_PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + (CMDQ_PTR_W+1)'(1);
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= r_rd_ptr + (CMDQ_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wr_ptr[CMDQ_PTR_W-1:0]] <= i_cmd;
        end
    end

endmodule

FILE: design/bpt_back.sv
// Back end: sequencer, pheromone memory, bound arithmetic and the result register.
module bpt_back
    import bpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    localparam int P1_W = AMT_W + INV_W;
    localparam int P2_W = FLOOR_W + VAL_W;
    localparam int PE_W = VAL_W + DECAY_W;

    t_state             r_state;
    t_state             n_state;
    t_cmd               r_cmd;
    logic [VAL_W-1:0]   r_mem [STORE_DEPTH];
    logic [VAL_W-1:0]   r_rd_data;
    logic [ADDR_W-1:0]  r_sweep;
    logic               r_ev_more;
    logic               r_ev_v1;
    logic               r_ev_v2;
    logic [IDX_W-1:0]   r_ev_row;
    logic [IDX_W-1:0]   r_ev_col;
    logic [ADDR_W-1:0]  r_ev_base;
    logic [ADDR_W-1:0]  r_ev_a1;
    logic [ADDR_W-1:0]  r_ev_a2;
    logic [PE_W-1:0]    r_prod;
    logic [P1_W-1:0]    r_p1;
    logic [AMT_W-1:0]   r_best;
    logic [VAL_W-1:0]   r_min;
    logic [VAL_W-1:0]   r_max;
    logic               r_improved;
    logic               r_out_valid;
    t_result            r_out;

    logic               offer_win;
    logic               out_free;
    logic [IDX_W-1:0]   last_idx;
    logic [ADDR_W-1:0]  ev_addr;
    logic [VAL_W-1:0]   ev_val;
    logic [VAL_W:0]     dep_sum;
    logic [VAL_W-1:0]   dep_val;
    logic [P2_W-1:0]    p2;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VAL_W-1:0]   wr_data;
    logic               res_push;
    logic               ev_issue;
    t_result            res;

    assign offer_win = (i_cmd.amount > r_best);
    assign out_free  = !r_out_valid || pop;
    assign last_idx  = IDX_W'(i_cfg.count - CNT_W'(1));
    assign ev_addr   = r_ev_base + ADDR_W'(r_ev_col);
    assign ev_issue  = (r_state == ST_EVAP) && r_ev_more;
    assign p2        = P2_W'(i_cfg.floor_ratio) * P2_W'(r_max);

    always_comb begin
        ev_val = r_prod[PE_W-1:FRAC_W];
        if (ev_val < r_min) begin
            ev_val = r_min;
        end
        if (ev_val > r_max) begin
            ev_val = r_max;
        end
    end

    always_comb begin
        dep_sum = {1'b0, r_rd_data} + (VAL_W+1)'(r_cmd.amount);
        if (dep_sum > {1'b0, r_max}) begin
            dep_sum = {1'b0, r_max};
        end
        if (dep_sum < {1'b0, r_min}) begin
            dep_sum = {1'b0, r_min};
        end
        dep_val = dep_sum[VAL_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_INIT:    n_state = ST_INIT;
                        OP_EVAP:    n_state = ST_EVAP;
                        OP_DEPOSIT: n_state = i_cmd.bad ? ST_FETCH : ST_DEP_WAIT;
                        OP_OFFER:   n_state = offer_win ? ST_BEST_MAX : ST_FETCH;
                        default:    n_state = ST_FETCH;
                    endcase
                end
            end
            ST_INIT: begin
                if (r_sweep == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_EVAP: begin
                if (!r_ev_more && !r_ev_v1 && !r_ev_v2) begin
                    n_state = ST_FETCH;
                end
            end
            ST_DEP_WAIT: n_state = ST_FETCH;
            ST_BEST_MAX: n_state = ST_BEST_MIN;
            ST_BEST_MIN: n_state = ST_FETCH;
            ST_FETCH:    n_state = ST_DATA;
            ST_DATA: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_cmd.addr;
        wr_en     = 1'b0;
        wr_addr   = r_cmd.addr;
        wr_data   = dep_val;
        res_push  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid && (i_cmd.op == OP_DEPOSIT) && !i_cmd.bad) begin
                    rd_en   = 1'b1;
                    rd_addr = i_cmd.addr;
                end
            end
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_sweep;
                wr_data = ONE_Q16;
            end
            ST_EVAP: begin
                rd_en   = r_ev_more;
                rd_addr = ev_addr;
                wr_en   = r_ev_v2;
                wr_addr = r_ev_a2;
                wr_data = ev_val;
            end
            ST_DEP_WAIT: begin
                wr_en = 1'b1;
            end
            ST_FETCH: begin
                rd_en = !r_cmd.bad;
            end
            ST_DATA: begin
                res_push = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ev_more   <= 1'b0;
            r_ev_v1     <= 1'b0;
            r_ev_v2     <= 1'b0;
            r_best      <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_improved  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ev_v1 <= ev_issue;
            r_ev_v2 <= r_ev_v1;
            if (o_cmd_pop) begin
                r_improved <= 1'b0;
                if (i_cmd.op == OP_EVAP) begin
                    r_ev_more <= (i_cfg.count != '0);
                end
                if ((i_cmd.op == OP_OFFER) && offer_win) begin
                    r_best     <= i_cmd.amount;
                    r_improved <= 1'b1;
                end
            end
            if (ev_issue && (r_ev_col == last_idx) && (r_ev_row == last_idx)) begin
                r_ev_more <= 1'b0;
            end
            if (r_state == ST_BEST_MAX) begin
                r_max <= VAL_W'(r_p1 >> FRAC_W);
            end
            if (r_state == ST_BEST_MIN) begin
                r_min <= VAL_W'(p2 >> FRAC_W);
            end
            if (res_push) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd     <= i_cmd;
            r_sweep   <= '0;
            r_ev_row  <= '0;
            r_ev_col  <= '0;
            r_ev_base <= '0;
            r_p1      <= P1_W'(i_cmd.amount) * P1_W'(i_cfg.inv_one_minus_rho);
        end
        if (r_state == ST_INIT) begin
            r_sweep <= r_sweep + ADDR_W'(1);
        end
        if (ev_issue) begin
            if (r_ev_col == last_idx) begin
                r_ev_col  <= '0;
                r_ev_row  <= r_ev_row + IDX_W'(1);
                r_ev_base <= r_ev_base + ADDR_W'(MAX_VERTICES);
            end else begin
                r_ev_col <= r_ev_col + IDX_W'(1);
            end
        end
        r_ev_a1 <= ev_addr;
        r_ev_a2 <= r_ev_a1;
        r_prod  <= PE_W'(r_rd_data) * PE_W'(i_cfg.decay);
        if (res_push) begin
            r_out <= res;
        end
    end

    always_comb begin
        res.entry_value = r_cmd.bad ? '0 : r_rd_data;
        res.best_score  = r_best;
        res.lower_bound = r_min;
        res.upper_bound = r_max;
        res.improved    = r_improved;
        res.status      = r_cmd.bad;
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule

FILE: design/bounded_pheromone_table_top.sv
// Top level of the bounded pheromone table: front end, command queue and back end.
//
// The block keeps a 64 by 64 table of Q16.16 pheromone values in a memory with one
// write and one read port, together with the best score and the lower and upper
// bounds. Item beats enter a four-deep command queue at one per cycle unless it is
// full; the back end runs one command at a time and leaves each result in an output
// register that waits for pop while the next command already runs. A read passes
// through a fetch and a data state, a deposit reads the entry and writes the bounded
// sum, an offer of a new best computes the upper and then the lower bound (two
// multiplications in sequence), an evaporate sweeps the active vertex count squared
// entries (one entry per cycle through a read, multiply and write pipeline on the
// memory ports), and an initialize makes one memory write per entry across the whole
// table. The table content is undefined after reset until an initialize has run.
// Configuration writes are always ready and must only be issued while the block is idle.
module bounded_pheromone_table_top
    import bpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in                   i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic cmd_push;
    logic cmd_full;
    logic cmd_valid;
    logic cmd_pop;

    bpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cmd_push  (cmd_push),
        .o_cmd       (front_cmd),
        .i_cmd_full  (cmd_full)
    );

    bpt_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .i_pop   (cmd_pop),
        .o_cmd   (head_cmd)
    );

    bpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    a_bad_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status) |-> (o_result.entry_value == '0))
        else $error("out-of-range result carries a nonzero entry value");

    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.lower_bound <= o_result.upper_bound))
        else $error("lower bound exceeds upper bound");

    a_upper_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.upper_bound[VAL_W-1:25] == '0))
        else $error("upper bound wider than 25 bits");

    a_improved_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.improved) |-> (o_result.best_score != '0))
        else $error("improvement reported with a zero best score");
`endif

endmodule

FILE: verif/bpt_checker.sv
// Checker for the bounded pheromone table: predicts each result beat and compares it.
`timescale 1ns / 100ps

module bpt_checker
    import bpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  t_in                   i_item,
    input  logic                  empty,
    input  logic                  pop,
    input  t_result               i_result,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    bit [VAL_W-1:0]   pheromone [STORE_DEPTH];
    bit [AMT_W-1:0]   best_score;
    bit [VAL_W-1:0]   floor_bound;
    bit [VAL_W-1:0]   ceil_bound;

    bit [VC_W-1:0]    vertex_count;
    bit [DECAY_W-1:0] decay;
    bit [INV_W-1:0]   inv_one_minus_rho;
    bit [FLOOR_W-1:0] floor_ratio;

    t_result expected_results [$];
    t_result want;
    int      fail_count = 0;

    function automatic t_result update_table(input t_in item);
        int unsigned      active;
        int unsigned      addr;
        int unsigned      r;
        int unsigned      c;
        bit               bad;
        bit [47:0]        prod;
        bit [32:0]        sum;
        bit [VAL_W-1:0]   v;
        t_result          res;
        active = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
        bad    = (item.row >= active) || (item.col >= active);
        addr   = item.row * MAX_VERTICES + item.col;
        res    = '0;
        case (item.opcode)
            OP_INIT: begin
                foreach (pheromone[k]) pheromone[k] = ONE_Q16;
            end
            OP_EVAP: begin
                for (r = 0; r < active; r++) begin
                    for (c = 0; c < active; c++) begin
                        prod = 48'(pheromone[r * MAX_VERTICES + c]) * 48'(decay);
                        v    = prod[47:16];
                        if (v < floor_bound) v = floor_bound;
                        if (v > ceil_bound) v = ceil_bound;
                        pheromone[r * MAX_VERTICES + c] = v;
                    end
                end
            end
            OP_DEPOSIT: begin
                if (!bad) begin
                    sum = 33'(pheromone[addr]) + 33'(item.amount);
                    if (sum > 33'(ceil_bound)) sum = 33'(ceil_bound);
                    if (sum < 33'(floor_bound)) sum = 33'(floor_bound);
                    pheromone[addr] = sum[VAL_W-1:0];
                end
            end
            OP_OFFER: begin
                if (item.amount > best_score) begin
                    best_score   = item.amount;
                    prod         = 48'(item.amount) * 48'(inv_one_minus_rho);
                    ceil_bound   = prod[47:16];
                    prod         = 48'(floor_ratio) * 48'(ceil_bound);
                    floor_bound  = prod[47:16];
                    res.improved = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.entry_value = bad ? '0 : pheromone[addr];
        res.best_score  = best_score;
        res.lower_bound = floor_bound;
        res.upper_bound = ceil_bound;
        res.status      = bad;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                               input logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            best_score        = '0;
            floor_bound       = '0;
            ceil_bound        = '0;
            vertex_count      = RST_VERTEX;
            decay             = RST_DECAY;
            inv_one_minus_rho = RST_INV;
            floor_ratio       = RST_FLOOR_RATIO;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_VERTEX_COUNT:      vertex_count = i_cfg_data[VC_W-1:0];
                    CFG_DECAY:             decay = i_cfg_data[DECAY_W-1:0];
                    CFG_INV_ONE_MINUS_RHO: inv_one_minus_rho = i_cfg_data[INV_W-1:0];
                    CFG_FLOOR_RATIO:       floor_ratio = i_cfg_data[FLOOR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("Result beat arrived with no expected result waiting.");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("entry_value", want.entry_value, i_result.entry_value);
                    check_field("best_score", VAL_W'(want.best_score),
                                VAL_W'(i_result.best_score));
                    check_field("lower_bound", want.lower_bound, i_result.lower_bound);
                    check_field("upper_bound", want.upper_bound, i_result.upper_bound);
                    check_field("improved", VAL_W'(want.improved),
                                VAL_W'(i_result.improved));
                    check_field("status", VAL_W'(want.status), VAL_W'(i_result.status));
                end
            end
            if (push && !full) expected_results.push_back(update_table(i_item));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: verif/testbench.sv
// Top of the bounded pheromone table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import bpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 25000;
    localparam int END_CYCLES     = 20;
    localparam int AMOUNT_MAX     = 65536;
    localparam int SCORE_CAP      = 65535;
    localparam int IDX_MAX        = MAX_VERTICES - 1;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_in                   i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_result               o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int vc_active = int'(RST_VERTEX);
    int best_offered = 0;
    int send_gap_pct = 20;
    int pop_stall_pct = 20;
    int stall_left = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    bounded_pheromone_table_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bpt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_item       (i_item),
        .empty        (empty),
        .pop          (pop),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if ($urandom_range(0, 99) < pop_stall_pct) begin
            stall_left = pick_gap() - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in make_item(input logic [OP_W-1:0] op, input int row, input int col,
                                      input int amount);
        t_in it;
        it.opcode = op;
        it.row    = row[ROW_W-1:0];
        it.col    = col[ROW_W-1:0];
        it.amount = amount[AMT_W-1:0];
        return it;
    endfunction

    task automatic send_item(input t_in it);
        int gap;
        gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
        if (it.opcode == OP_OFFER && int'(it.amount) > best_offered) begin
            best_offered = int'(it.amount);
        end
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int unsigned data);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_vertex_count(input int vc);
        write_reg(CFG_VERTEX_COUNT, vc);
        vc_active = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
    endtask

    task automatic configure(input int vc, input int unsigned dec, input int unsigned inv,
                             input int unsigned flr);
        set_vertex_count(vc);
        write_reg(CFG_DECAY, dec);
        write_reg(CFG_INV_ONE_MINUS_RHO, inv);
        write_reg(CFG_FLOOR_RATIO, flr);
    endtask

    task automatic send_random();
        int               pick;
        int               evap_pct;
        int               row;
        int               col;
        int               amount;
        logic [OP_W-1:0]  op;
        pick     = $urandom_range(0, 99);
        evap_pct = (vc_active > 16) ? 1 : 6;
        if (pick < 1) op = OP_INIT;
        else if (pick < 1 + evap_pct) op = OP_EVAP;
        else if (pick < 40) op = OP_DEPOSIT;
        else if (pick < 54) op = OP_OFFER;
        else if (pick < 97) op = OP_READ;
        else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if (vc_active == 0 || $urandom_range(0, 99) < 12) begin
            row = $urandom_range(0, IDX_MAX);
            col = $urandom_range(0, IDX_MAX);
        end else begin
            row = $urandom_range(0, vc_active - 1);
            col = $urandom_range(0, vc_active - 1);
        end
        if (op == OP_DEPOSIT) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) amount = 0;
            else if (pick == 1) amount = AMOUNT_MAX;
            else if (pick < 6) amount = $urandom_range(0, 4095);
            else amount = $urandom_range(0, AMOUNT_MAX);
        end else if (op == OP_OFFER) begin
            if (best_offered < SCORE_CAP && $urandom_range(0, 99) < 55) begin
                amount = best_offered + $urandom_range(1, 400);
                if (amount > SCORE_CAP) amount = SCORE_CAP;
            end else begin
                amount = $urandom_range(0, best_offered);
            end
        end else begin
            amount = $urandom_range(0, AMOUNT_MAX);
        end
        send_item(make_item(op, row, col, amount));
    endtask

    task automatic run_phase(input int vc, input int unsigned dec, input int unsigned inv,
                             input int unsigned flr, input int count);
        configure(vc, dec, inv, flr);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_gap_pct  = 0;
                    pop_stall_pct = 0;
                end else begin
                    send_gap_pct  = $urandom_range(10, 40);
                    pop_stall_pct = $urandom_range(10, 40);
                end
            end
            if (i == count / 2) drain();
            send_random();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(make_item(OP_INIT, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, AMOUNT_MAX));
        send_item(make_item(OP_READ, IDX_MAX, IDX_MAX, 0));
        send_item(make_item(OP_OFFER, 4, 4, 0));
        send_item(make_item(OP_DEPOSIT, 1, 2, 100));
        send_item(make_item(OP_READ, 1, 2, 0));
        send_item(make_item(OP_OFFER, 0, 0, 1000));
        send_item(make_item(OP_DEPOSIT, 0, 0, AMOUNT_MAX));
        send_item(make_item(OP_DEPOSIT, 5, 6, 0));
        send_item(make_item(OP_OFFER, 0, 0, 999));
        send_item(make_item(OP_OFFER, 0, 0, 1000));
        send_item(make_item(OP_EVAP, IDX_MAX, 0, 0));
        send_item(make_item(OP_READ, 1, 2, 0));
        send_item(make_item(OP_SPARE_FIRST, 0, 0, AMOUNT_MAX));
        send_item(make_item(OP_SPARE_FIRST + 3'd1, 7, 9, 77));
        send_item(make_item(OP_SPARE_LAST, IDX_MAX, IDX_MAX, 0));
        send_item(make_item(OP_INIT, 0, 0, 0));

        set_vertex_count(3);
        send_item(make_item(OP_READ, 3, 0, 0));
        send_item(make_item(OP_DEPOSIT, 0, 5, 50));
        send_item(make_item(OP_EVAP, 0, 0, 0));
        send_item(make_item(OP_READ, 2, 2, 0));

        set_vertex_count(0);
        send_item(make_item(OP_EVAP, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0));

        set_vertex_count(100);
        send_item(make_item(OP_READ, IDX_MAX, IDX_MAX, 0));
        send_item(make_item(OP_DEPOSIT, IDX_MAX, 0, AMOUNT_MAX));

        run_phase(64, 52429, 327680, 328, 150);
        run_phase(8, 45000, 200000, 3000, 200);
        run_phase(1, 0, 65536, 0, 120);
        run_phase(64, 65535, 16777215, 65535, 150);
        run_phase(0, 30000, 500000, 1000, 40);
        run_phase(127, $urandom_range(0, 65535), $urandom_range(65536, 16777215),
                  $urandom_range(0, 65535), 150);
        run_phase($urandom_range(2, 20), $urandom_range(0, 65535),
                  $urandom_range(65536, 16777215), $urandom_range(0, 65535), 290);

        send_item(make_item(OP_OFFER, 0, 0, AMOUNT_MAX));
        send_item(make_item(OP_OFFER, 1, 1, AMOUNT_MAX));
        send_item(make_item(OP_DEPOSIT, 1, 0, AMOUNT_MAX));

        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
